>>> hw/rtl/stsm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted table salvage matcher.
// No dependencies; imported by the controller, datapath and top level.
package stsm_pkg;

	localparam int IDX_W  = 10;
	localparam int DATA_W = 32;
	localparam int CNT_W  = 16;
	localparam int CFG_W  = 11;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_PROBE = 1'b1;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic load_wr;
		logic start;
		logic look;
		logic finish;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic count_zero;
		logic search_done;
		logic out_free;
	} sts_t;

endpackage

>>> hw/rtl/stsm_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// No dependencies.
module stsm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/stsm_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences loads and binary-search probes.
// Depends on stsm_pkg.
module stsm_ctrl
	import stsm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic mode,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_LOAD  = 5'b00010,
		ST_START = 5'b00100,
		ST_LOOK  = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	state_t state_q, state_n;

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_n     = (mode == MODE_PROBE) ? ST_START : ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load_wr = 1'b1;
				state_n     = ST_IDLE;
			end
			ST_START: begin
				cmd.start = 1'b1;
				state_n   = sts.count_zero ? ST_FIN : ST_LOOK;
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				if (sts.search_done) begin
					state_n = ST_FIN;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_n    = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

>>> hw/rtl/stsm_dp.sv
`timescale 1ns / 1ps
// Datapath: item registers, table RAMs, search bounds, salvage counter, result register.
// Depends on stsm_pkg and stsm_ram.
module stsm_dp
	import stsm_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              cfg_wr_en,
	input  logic [CFG_W-1:0]  cfg_wr_data,
	input  logic [IDX_W-1:0]  entry_index,
	input  logic [DATA_W-1:0] entry_offset,
	input  logic [DATA_W-1:0] entry_length,
	input  logic [DATA_W-1:0] record_tag,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              matched,
	output logic [IDX_W-1:0]  match_position,
	output logic [CNT_W-1:0]  salvaged_count
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int IW = (AW > IDX_W) ? AW : IDX_W;
	localparam logic [31:0] DEPTH_W = TABLE_DEPTH;

	logic [IDX_W-1:0]  idx_q;
	logic [DATA_W-1:0] off_q, len_q, tag_q;
	logic [CFG_W-1:0]  entry_count_q;
	logic [CW-1:0]     lo_q, hi_q;
	logic [AW-1:0]     mid_q;
	logic              hit_q;
	logic [CNT_W-1:0]  salvage_q;
	logic              out_valid_q, matched_q;
	logic [IDX_W-1:0]  pos_q;
	logic [CNT_W-1:0]  count_out_q;

	logic [IW-1:0]       ld_ext, pos_ext;
	logic [AW-1:0]       ld_addr, mid0, nxt_mid, ol_addr, tag_addr;
	logic                idx_ok, ol_we, tag_we;
	logic [CW-1:0]       cnt, lo_n, hi_n;
	logic [CW:0]         sum0, sum1;
	logic [2*DATA_W-1:0] ol_rdata;
	logic [DATA_W-1:0]   rd_off, rd_len;
	logic                off_eq, off_lt, done;
	logic [CNT_W-1:0]    salvage_n;

	assign ld_ext  = IW'(idx_q);
	assign ld_addr = ld_ext[AW-1:0];
	assign idx_ok  = (32'(idx_q) < DEPTH_W);

	assign cnt  = (32'(entry_count_q) > DEPTH_W) ? CW'(TABLE_DEPTH) : CW'(entry_count_q);
	assign sum0 = {1'b0, cnt} - (CW+1)'(1);
	assign mid0 = AW'(sum0 >> 1);

	assign rd_off = ol_rdata[2*DATA_W-1:DATA_W];
	assign rd_len = ol_rdata[DATA_W-1:0];
	assign off_eq = (off_q == rd_off);
	assign off_lt = (off_q < rd_off);

	always_comb begin
		lo_n = lo_q;
		hi_n = hi_q;
		if (!off_eq) begin
			if (off_lt) begin
				hi_n = CW'(mid_q);
			end else begin
				lo_n = CW'(mid_q) + CW'(1);
			end
		end
	end

	assign done    = off_eq || (lo_n >= hi_n);
	assign sum1    = {1'b0, lo_n} + {1'b0, hi_n} - (CW+1)'(1);
	assign nxt_mid = AW'(sum1 >> 1);

	assign ol_we    = cmd.load_wr && idx_ok;
	assign ol_addr  = cmd.load_wr ? ld_addr : (cmd.start ? mid0 : nxt_mid);
	assign tag_we   = (cmd.load_wr && idx_ok) || (cmd.finish && hit_q);
	assign tag_addr = cmd.load_wr ? ld_addr : mid_q;

	stsm_ram #(.WIDTH(2*DATA_W), .DEPTH(TABLE_DEPTH)) u_ol_ram (
		.clk   (clk),
		.we    (ol_we),
		.addr  (ol_addr),
		.wdata ({off_q, len_q}),
		.rdata (ol_rdata)
	);

	stsm_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.addr  (tag_addr),
		.wdata (tag_q),
		.rdata ()
	);

	assign salvage_n = (hit_q && salvage_q != CNT_MAX) ? salvage_q + CNT_W'(1) : salvage_q;
	assign pos_ext   = IW'(mid_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q <= entry_index;
			off_q <= entry_offset;
			len_q <= entry_length;
			tag_q <= record_tag;
		end
		if (cmd.start) begin
			lo_q  <= '0;
			hi_q  <= cnt;
			mid_q <= mid0;
			hit_q <= 1'b0;
		end else if (cmd.look) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			hit_q <= off_eq && (len_q == rd_len);
			if (!off_eq) begin
				mid_q <= nxt_mid;
			end
		end
		if (cmd.finish) begin
			matched_q   <= hit_q;
			pos_q       <= hit_q ? pos_ext[IDX_W-1:0] : '0;
			count_out_q <= salvage_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			salvage_q     <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				entry_count_q <= cfg_wr_data;
			end
			if (cmd.finish) begin
				salvage_q   <= salvage_n;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.count_zero  = (cnt == '0);
	assign sts.search_done = done;
	assign sts.out_free    = !out_valid_q || !out_stall;

	assign out_valid      = out_valid_q;
	assign matched        = matched_q;
	assign match_position = pos_q;
	assign salvaged_count = count_out_q;

endmodule

>>> hw/rtl/sorted_table_salvage_matcher_core.sv
`timescale 1ns / 1ps
// Sorted table exact-match search with tag salvage. Load: capture, then table write.
// Probe: capture, start, search steps, finish; steps <= floor(log2(entry_count)) + 1
// (11 at 1024 entries); one RAM read per step sets the pace. One item at a time.
// A result waits in the output register while the next item is taken.
// arst_n clears control, entry_count and the salvage counter; table RAMs are not cleared.
module sorted_table_salvage_matcher_core
	import stsm_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CFG_W-1:0]  cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              mode,
	input  logic [IDX_W-1:0]  entry_index,
	input  logic [DATA_W-1:0] entry_offset,
	input  logic [DATA_W-1:0] entry_length,
	input  logic [DATA_W-1:0] record_tag,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              matched,
	output logic [IDX_W-1:0]  match_position,
	output logic [CNT_W-1:0]  salvaged_count
);

	cmd_t cmd;
	sts_t sts;

	stsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	stsm_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.entry_index    (entry_index),
		.entry_offset   (entry_offset),
		.entry_length   (entry_length),
		.record_tag     (record_tag),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.matched        (matched),
		.match_position (match_position),
		.salvaged_count (salvaged_count)
	);

	a_finish_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free)
		else $error("result written while output slot busy");

	a_probe_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && mode == MODE_PROBE) |=> cmd.start)
		else $error("accepted probe did not start a search");

	a_search_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.look && sts.search_done) |=> !cmd.look)
		else $error("search continued after completion");

	a_finish_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid)
		else $error("finished probe produced no result");

endmodule
